@@ hw/rtl/htr_pkg.sv @@
// Package for the rate-limited heading tracker.
// Holds shared widths, the CORDIC arctangent table, sequencer states and control structs.
// No dependencies.
package htr_pkg;

    // Default parameter values
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 7;

    // Fixed datapath formats
    localparam int Q_ANGLE   = 20;  // CORDIC angle in 2^-20 degree
    localparam int VEC_SHIFT = 16;  // vector prescale
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = 5;
    localparam int D_W       = 14;  // signed target-minus-centre offset
    localparam int XY_W      = 32;
    localparam int Z_W       = 32;
    localparam int OUT_W     = 16;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Half and full turn in CORDIC angle units
    localparam logic signed [Z_W-1:0] HALF_Q = Z_W'(180) <<< Q_ANGLE;
    localparam logic signed [Z_W-1:0] FULL_Q = Z_W'(360) <<< Q_ANGLE;

    // Register map indexes
    typedef enum logic [1:0] {
        REG_CENTRE_X  = 2'd0,
        REG_CENTRE_Y  = 2'd1,
        REG_TURN_RATE = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROTATE,
        S_ROUND,
        S_DIFF,
        S_DONE
    } state_t;

    // CORDIC unit controls
    typedef struct packed {
        logic             load;
        logic             rotate;
        logic [IDX_W-1:0] iter;
    } cordic_ctrl_t;

    // Turn unit controls
    typedef struct packed {
        logic mul_en;
        logic diff_en;
    } turn_ctrl_t;

    // atan(2^-i) in degrees, Q20
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 47185920;
            5'd1:    v = 27855475;
            5'd2:    v = 14718068;
            5'd3:    v = 7471121;
            5'd4:    v = 3750058;
            5'd5:    v = 1876857;
            5'd6:    v = 938658;
            5'd7:    v = 469357;
            5'd8:    v = 234682;
            5'd9:    v = 117342;
            5'd10:   v = 58671;
            5'd11:   v = 29335;
            5'd12:   v = 14668;
            5'd13:   v = 7334;
            5'd14:   v = 3667;
            5'd15:   v = 1833;
            5'd16:   v = 917;
            5'd17:   v = 458;
            5'd18:   v = 229;
            5'd19:   v = 115;
            5'd20:   v = 57;
            5'd21:   v = 29;
            5'd22:   v = 14;
            5'd23:   v = 7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/htr_cordic.sv @@
// Shared CORDIC vectoring unit: one micro-rotation per cycle on x, y and angle.
// Depends on htr_pkg.
module htr_cordic (
    input  logic                              clk,
    input  htr_pkg::cordic_ctrl_t             ctrl,
    input  logic signed [htr_pkg::D_W-1:0]    dx,
    input  logic signed [htr_pkg::D_W-1:0]    dy,
    output logic signed [htr_pkg::Z_W-1:0]    z
);
    import htr_pkg::*;

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [D_W-1:0]  ax, ay;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;

    // Fold left half plane into the right, prescale, or rotate one step
    always_comb
    begin
        ax  = dx[D_W-1] ? -dx : dx;
        ay  = dx[D_W-1] ? -dy : dy;
        xs  = x_reg >>> ctrl.iter;
        ys  = y_reg >>> ctrl.iter;
        ang = atan_q20(ctrl.iter);
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctrl.load)
        begin
            x_next = XY_W'(ax) <<< VEC_SHIFT;
            y_next = XY_W'(ay) <<< VEC_SHIFT;
            z_next = dx[D_W-1] ? HALF_Q : '0;
        end
        else if (ctrl.rotate)
        begin
            if (y_reg[XY_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
        end
    end

    // Hold vector and angle
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign z = z_reg;

endmodule

@@ hw/rtl/htr_turn.sv @@
// Turn unit: step size from rate and time, short-way distance, and heading update.
// Depends on htr_pkg.
module htr_turn #(
    parameter int ANGLE_FRACTION_BITS = htr_pkg::ANGLE_FRAC_DEF,
    parameter int ANGLE_W = 16
) (
    input  logic                   clk,
    input  htr_pkg::turn_ctrl_t    ctrl,
    input  logic [15:0]            turn_rate,
    input  logic [15:0]            elapsed,
    input  logic [ANGLE_W-1:0]     bearing,
    input  logic [ANGLE_W-1:0]     head,
    output logic [ANGLE_W-1:0]     new_head
);
    import htr_pkg::*;

    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 << ANGLE_FRACTION_BITS);
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 << ANGLE_FRACTION_BITS);
    localparam int PROD_W = 32;
    localparam int STEP_W = PROD_W - 10;

    logic [PROD_W-1:0]  prod;
    logic [STEP_W-1:0]  step_raw;
    logic [ANGLE_W-1:0] step_reg, step_next;
    logic [ANGLE_W-1:0] absd, shortd_reg, shortd_next;
    logic               up_raw, up_reg, up_next;
    logic [ANGLE_W-1:0] move;
    logic [ANGLE_W:0]   sum_up, sum_dn;

    // Step = rate * time / 1024, saturated to half a turn
    always_comb
    begin
        prod      = PROD_W'(turn_rate) * PROD_W'(elapsed);
        step_raw  = prod[PROD_W-1:10];
        step_next = step_reg;
        if (ctrl.mul_en)
        begin
            if (step_raw > STEP_W'(HALF_TURN))
                step_next = HALF_TURN;
            else
                step_next = step_raw[ANGLE_W-1:0];
        end
    end

    // Short-way distance and direction
    always_comb
    begin
        up_raw      = (bearing >= head);
        absd        = up_raw ? (bearing - head) : (head - bearing);
        shortd_next = shortd_reg;
        up_next     = up_reg;
        if (ctrl.diff_en)
        begin
            if (absd > HALF_TURN)
            begin
                shortd_next = FULL_TURN - absd;
                up_next     = !up_raw;
            end
            else
            begin
                shortd_next = absd;
                up_next     = up_raw;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        shortd_reg <= shortd_next;
        up_reg     <= up_next;
    end

    // Advance heading by the clamped move and wrap
    always_comb
    begin
        move   = (step_reg < shortd_reg) ? step_reg : shortd_reg;
        sum_up = {1'b0, head} + {1'b0, move};
        sum_dn = {1'b0, head} + {1'b0, FULL_TURN} - {1'b0, move};
        if (up_reg)
        begin
            if (sum_up >= {1'b0, FULL_TURN})
                new_head = ANGLE_W'(sum_up - {1'b0, FULL_TURN});
            else
                new_head = sum_up[ANGLE_W-1:0];
        end
        else
        begin
            if (head >= move)
                new_head = head - move;
            else
                new_head = sum_dn[ANGLE_W-1:0];
        end
    end

endmodule

@@ hw/rtl/heading_tracker_rate_limited.sv @@
// Top level of the rate-limited heading tracker: APB registers, sequencer, output register.
// Depends on htr_pkg, htr_cordic and htr_turn.
//
// Each transfer on the input channel gives a target point and the time since
// the previous one; the block answers with one result holding the bearing from
// the configured centre to the target and the new heading, which has turned
// toward that bearing the short way by at most turn_rate * elapsed / 1024.
// Angles are unsigned degrees with ANGLE_FRACTION_BITS fraction bits. Each
// result takes CORDIC_STEPS micro-rotations in a single shared unit, then
// one state each to round the bearing, find the short-way distance and load
// the output register. in_ready is high only while the sequencer is idle, so
// the next input transfer is taken only once the previous item has been
// loaded into the output register. The finished result sits in an output
// register, so the next item can be taken while it waits to be read; that item
// stalls in S_DONE until the output register is free. Registers sit at byte
// addresses 0 (centre_x), 4 (centre_y) and 8 (turn_rate).
module heading_tracker_rate_limited #(
    parameter int CORDIC_STEPS        = htr_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = htr_pkg::ANGLE_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htr_pkg::PADDR_W-1:0]   paddr,
    input  logic [htr_pkg::PDATA_W-1:0]   pwdata,
    output logic [htr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [11:0]            target_x,
    input  logic signed [11:0]            target_y,
    input  logic [15:0]                   elapsed,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   heading,
    output logic [15:0]                   bearing
);
    import htr_pkg::*;

    localparam int FULL_TURN_I = 360 << ANGLE_FRACTION_BITS;
    localparam int ANGLE_W     = $clog2(FULL_TURN_I);
    localparam int WIDE_W      = (ANGLE_W > OUT_W) ? ANGLE_W : OUT_W;
    localparam int SH          = Q_ANGLE - ANGLE_FRACTION_BITS;
    localparam int ITER_W      = $clog2(CORDIC_STEPS);
    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(FULL_TURN_I);
    localparam logic [Z_W-1:0]     RND_HALF  = Z_W'(1) << (SH - 1);
    localparam logic [ITER_W-1:0]  LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    // Configuration registers
    logic [10:0] centre_x_reg;
    logic [10:0] centre_y_reg;
    logic [15:0] turn_rate_reg;
    reg_idx_t    wr_idx;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg  <= 11'd400;
            centre_y_reg  <= 11'd300;
            turn_rate_reg <= 16'd1920;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_CENTRE_X:  centre_x_reg  <= pwdata[10:0];
                REG_CENTRE_Y:  centre_y_reg  <= pwdata[10:0];
                REG_TURN_RATE: turn_rate_reg <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (wr_idx)
            REG_CENTRE_X:  prdata = PDATA_W'(centre_x_reg);
            REG_CENTRE_Y:  prdata = PDATA_W'(centre_y_reg);
            REG_TURN_RATE: prdata = PDATA_W'(turn_rate_reg);
            default:       prdata = '0;
        endcase
    end

    // Sequencer and datapath registers
    state_t               state_reg, state_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     head_reg, head_next;
    logic [OUT_W-1:0]     heading_reg, heading_next;
    logic [OUT_W-1:0]     bearing_out_reg, bearing_out_next;
    logic [ANGLE_W-1:0]   bearing_reg, bearing_next;
    logic                 zero_reg, zero_next;

    logic                 in_xfer;
    logic                 load_out;
    logic signed [D_W-1:0] dx, dy;
    cordic_ctrl_t         cordic_ctrl;
    turn_ctrl_t           turn_ctrl;
    logic signed [Z_W-1:0] z;
    logic signed [Z_W-1:0] z_wrap;
    logic [Z_W-1:0]       rnd_sum;
    logic [Z_W-1:0]       rnd_sh;
    logic [ANGLE_W-1:0]   rnd;
    logic [WIDE_W-1:0]    head_wide;
    logic [ANGLE_W-1:0]   head;
    logic [ANGLE_W-1:0]   new_head;
    logic [WIDE_W-1:0]    new_head_wide;
    logic [WIDE_W-1:0]    bearing_wide;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign dx = D_W'(target_x) - D_W'({1'b0, centre_x_reg});
    assign dy = D_W'(target_y) - D_W'({1'b0, centre_y_reg});

    // Wrap the CORDIC angle and round to the output format
    always_comb
    begin
        z_wrap  = z[Z_W-1] ? (z + FULL_Q) : z;
        rnd_sum = z_wrap + RND_HALF;
        rnd_sh  = rnd_sum >> SH;
        rnd     = rnd_sh[ANGLE_W-1:0];
        if (rnd >= FULL_TURN)
            rnd = rnd - FULL_TURN;
    end

    assign head_wide     = WIDE_W'(head_reg);
    assign head          = head_wide[ANGLE_W-1:0];
    assign new_head_wide = WIDE_W'(new_head);
    assign bearing_wide  = WIDE_W'(bearing_reg);

    // Next state and unit controls
    always_comb
    begin
        state_next       = state_reg;
        iter_next        = iter_reg;
        out_valid_next   = out_valid_reg;
        head_next        = head_reg;
        heading_next     = heading_reg;
        bearing_out_next = bearing_out_reg;
        bearing_next     = bearing_reg;
        zero_next        = zero_reg;
        cordic_ctrl.load   = 1'b0;
        cordic_ctrl.rotate = 1'b0;
        cordic_ctrl.iter   = IDX_W'(iter_reg);
        turn_ctrl.mul_en   = 1'b0;
        turn_ctrl.diff_en  = 1'b0;
        load_out           = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cordic_ctrl.load = 1'b1;
                    turn_ctrl.mul_en = 1'b1;
                    zero_next        = (dx == '0) && (dy == '0);
                    iter_next        = '0;
                    state_next       = S_ROTATE;
                end
            end
            S_ROTATE:
            begin
                cordic_ctrl.rotate = 1'b1;
                iter_next          = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                bearing_next = zero_reg ? '0 : rnd;
                state_next   = S_DIFF;
            end
            S_DIFF:
            begin
                turn_ctrl.diff_en = 1'b1;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out         = 1'b1;
                    out_valid_next   = 1'b1;
                    head_next        = new_head_wide[OUT_W-1:0];
                    heading_next     = new_head_wide[OUT_W-1:0];
                    bearing_out_next = bearing_wide[OUT_W-1:0];
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg     <= heading_next;
        bearing_out_reg <= bearing_out_next;
        bearing_reg     <= bearing_next;
        zero_reg        <= zero_next;
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;
    assign bearing   = bearing_out_reg;

    htr_cordic u_cordic (
        .clk  (clk),
        .ctrl (cordic_ctrl),
        .dx   (dx),
        .dy   (dy),
        .z    (z)
    );

    htr_turn #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
        .ANGLE_W             (ANGLE_W)
    ) u_turn (
        .clk       (clk),
        .ctrl      (turn_ctrl),
        .turn_rate (turn_rate_reg),
        .elapsed   (elapsed),
        .bearing   (bearing_reg),
        .head      (head),
        .new_head  (new_head)
    );

`ifndef SYNTHESIS
    // An input transfer starts the rotation loop
    a_start_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_ROTATE) && (iter_reg == '0))
        else $error("input transfer did not start the CORDIC loop");

    // The loop ends after the last micro-rotation
    a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROTATE) && (iter_reg == LAST_ITER) |=> (state_reg == S_ROUND))
        else $error("CORDIC loop overran its step count");

    // Rounded bearing lies inside one turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |-> (bearing_reg < FULL_TURN))
        else $error("bearing outside one turn");

    // Updated heading lies inside one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (new_head < FULL_TURN))
        else $error("new heading outside one turn");

    // A result is loaded only when the output register is free or drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending output");
`endif

endmodule
